// ----- hw/rtl/kbf_pkg.sv -----
// package for the keyboard fifo register block: codes and defaults
`default_nettype none
package kbf_pkg;

	localparam int KBF_DEPTH = 16;

	localparam logic [1:0] MODE_PRESS   = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_READ    = 2'd2;

	localparam logic [1:0] OFF_STATUS   = 2'd0;
	localparam logic [1:0] OFF_CURRENT  = 2'd1;
	localparam logic [1:0] OFF_MODIFIER = 2'd2;
	localparam logic [1:0] OFF_POP      = 2'd3;

	localparam logic [7:0] STATUS_CONNECTED = 8'h80;
	localparam logic [7:0] STATUS_PENDING   = 8'h01;

endpackage
`default_nettype wire

// ----- hw/rtl/keyboard_fifo_registers_core.sv -----
// keyboard key fifo with four read registers, memory based
//
// channel   direction  handshake                 payload
// command   in         start && !busy            mode, key, reg_offset
// result    out        done (one-cycle strobe)   read_data, accepted, irq
//
// one result word for every command word; done and the result word are registered
// press, status read, modifier read, unused mode: accepted and finished without leaving idle
// pop reads (offsets 1 and 3): front entry read at accept, next entry read in POP1, result in POP2
// release: one memory read per queued entry, survivors written to the other bank as their
// reads return, then a drain and a finish step and the banks swap; no read when the fifo is empty
// reset (arst_n low) empties the fifo and clears current key and pending; the key
// memory itself is not cleared, entries are only read after they are written
// the receiver cannot stall; irq is the pending flag and always reflects the last step
`default_nettype none
module keyboard_fifo_registers_core
	import kbf_pkg::*;
#(
	parameter int DEPTH = KBF_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] mode,
	input  wire logic [7:0] key,
	input  wire logic [1:0] reg_offset,
	output logic            done,
	output logic [7:0]      read_data,
	output logic            accepted,
	output logic            irq
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP1,
		S_POP2,
		S_REL
	} state_t;

	// two banks of 2**AW entries: a release reads the live bank and packs
	// survivors into the other one, then the banks swap
	logic [7:0] mem_q [2**(AW+1)];
	logic [7:0] rd_data_q;

	state_t      state_q;
	logic          bank_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [7:0]    current_q;
	logic          pending_q;

	// command latched at accept, popped value latched in POP1
	logic [7:0] key_q;
	logic [1:0] off_q;
	logic [7:0] pop_val_q;

	// release walk
	logic [AW-1:0] rel_p_q;
	logic [CW-1:0] rel_rd_q;
	logic [CW-1:0] rel_n_q;
	logic          rel_vld_s1;
	logic [7:0]    first_q;

	// result registers
	logic       done_q;
	logic [7:0] read_data_q;
	logic       accepted_q;

	// memory port controls
	logic          mem_re;
	logic [AW:0]   mem_raddr;
	logic          mem_we;
	logic [AW:0]   mem_waddr;
	logic [7:0]    mem_wdata;

	logic          accept;
	logic          press_ok;
	logic          rel_issue;
	logic          rel_keep;
	logic          rel_finish;
	logic [AW-1:0] head_next;

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		if (p == AW'(DEPTH - 1)) begin
			return '0;
		end
		return p + AW'(1);
	endfunction

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign press_ok  = (key != 8'd0) && (count_q < CW'(DEPTH));
	assign head_next = nxt(head_q);

	assign rel_issue  = (rel_rd_q != count_q);
	assign rel_keep   = rel_vld_s1 && (rd_data_q != key_q);
	assign rel_finish = !rel_issue && !rel_vld_s1;

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = {bank_q, head_q};
		mem_we    = 1'b0;
		mem_waddr = {bank_q, tail_q};
		mem_wdata = key;
		case (state_q)
			S_IDLE: begin
				if (accept && mode == MODE_PRESS && press_ok) begin
					mem_we = 1'b1;
				end
				// first pop read: front entry
				if (accept && mode == MODE_READ &&
				    (reg_offset == OFF_CURRENT || reg_offset == OFF_POP)) begin
					mem_re = 1'b1;
				end
			end
			S_POP1: begin
				// second pop read: the entry that becomes the front
				mem_re    = 1'b1;
				mem_raddr = {bank_q, head_next};
			end
			S_REL: begin
				mem_re    = rel_issue;
				mem_raddr = {bank_q, rel_p_q};
				mem_we    = rel_keep;
				mem_waddr = {~bank_q, rel_n_q[AW-1:0]};
				mem_wdata = rd_data_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bank_q      <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			current_q   <= 8'd0;
			pending_q   <= 1'b0;
			rel_vld_s1  <= 1'b0;
			done_q      <= 1'b0;
			read_data_q <= 8'd0;
			accepted_q  <= 1'b0;
			key_q       <= 8'd0;
			off_q       <= 2'd0;
			pop_val_q   <= 8'd0;
			rel_p_q     <= '0;
			rel_rd_q    <= '0;
			rel_n_q     <= '0;
			first_q     <= 8'd0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q       <= key;
						off_q       <= reg_offset;
						read_data_q <= 8'd0;
						accepted_q  <= 1'b0;
						case (mode)
							MODE_PRESS: begin
								done_q <= 1'b1;
								if (press_ok) begin
									accepted_q <= 1'b1;
									tail_q     <= nxt(tail_q);
									count_q    <= count_q + CW'(1);
									if (!pending_q) begin
										current_q <= key;
										pending_q <= 1'b1;
									end
								end
							end
							MODE_RELEASE: begin
								rel_p_q    <= head_q;
								rel_rd_q   <= '0;
								rel_n_q    <= '0;
								rel_vld_s1 <= 1'b0;
								state_q    <= S_REL;
							end
							MODE_READ: begin
								case (reg_offset)
									OFF_STATUS: begin
										done_q      <= 1'b1;
										read_data_q <= STATUS_CONNECTED |
										               (pending_q ? STATUS_PENDING : 8'd0);
									end
									OFF_MODIFIER: begin
										done_q <= 1'b1;
									end
									default: begin
										state_q <= S_POP1;
									end
								endcase
							end
							default: begin
								// unused mode: no state change
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_POP1: begin
					if (count_q != '0) begin
						pop_val_q <= rd_data_q;
						head_q    <= head_next;
						count_q   <= count_q - CW'(1);
					end else begin
						pop_val_q <= current_q;
					end
					state_q <= S_POP2;
				end
				S_POP2: begin
					// current_q still holds the pre-pop key here
					read_data_q <= (off_q == OFF_CURRENT) ? current_q : pop_val_q;
					if (count_q != '0) begin
						current_q <= rd_data_q;
						pending_q <= 1'b1;
					end else begin
						pending_q <= 1'b0;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_REL: begin
					rel_vld_s1 <= rel_issue;
					if (rel_issue) begin
						rel_p_q  <= nxt(rel_p_q);
						rel_rd_q <= rel_rd_q + CW'(1);
					end
					if (rel_keep) begin
						rel_n_q <= rel_n_q + CW'(1);
						if (rel_n_q == '0) begin
							first_q <= rd_data_q;
						end
					end
					if (rel_finish) begin
						bank_q  <= ~bank_q;
						head_q  <= '0;
						tail_q  <= (rel_n_q == CW'(DEPTH)) ? '0 : rel_n_q[AW-1:0];
						count_q <= rel_n_q;
						if (rel_n_q != '0) begin
							current_q <= first_q;
							pending_q <= 1'b1;
						end else if (current_q == key_q) begin
							current_q <= 8'd0;
							pending_q <= 1'b0;
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done      = done_q;
	assign read_data = read_data_q;
	assign accepted  = accepted_q;
	assign irq       = pending_q;

endmodule
`default_nettype wire

// ----- dv/keyboard_fifo_registers_core_tb.sv -----
// self-checking testbench for the keyboard key fifo register block
`timescale 1ns / 100ps

import kbf_pkg::*;

// one result word as the block reports it
typedef struct packed {
	logic [7:0] data;
	logic       accepted;
	logic       irq;
} key_result_t;

typedef logic [$clog2(KBF_DEPTH)-1:0] slot_t;
typedef logic [$clog2(KBF_DEPTH):0]   level_t;

// keeps a shadow of the key fifo, predicts each result word and checks it
class key_fifo_checker;
	logic [7:0]  key_mem [KBF_DEPTH];
	slot_t       head_ptr;
	slot_t       tail_ptr;
	level_t      fill;
	logic [7:0]  cur_key;
	logic        pending;
	key_result_t expected_words [$];
	int          errors;

	function new();
		head_ptr = '0;
		tail_ptr = '0;
		fill     = '0;
		cur_key  = '0;
		pending  = 1'b0;
		errors   = 0;
	endfunction

	// pop: front entry if any, else the current key; refresh current and pending
	function logic [7:0] pop_key();
		logic [7:0] v;
		v = cur_key;
		if (fill != 0) begin
			v        = key_mem[head_ptr];
			head_ptr = head_ptr + 1'b1;
			fill     = fill - 1'b1;
		end
		if (fill != 0) begin
			cur_key = key_mem[head_ptr];
			pending = 1'b1;
		end else begin
			pending = 1'b0;
		end
		return v;
	endfunction

	// release: drop every copy of k, compact the rest to the front in order
	function void release_key(logic [7:0] k);
		logic [7:0] keep [KBF_DEPTH];
		int         n;
		int         i;
		slot_t      p;
		n = 0;
		p = head_ptr;
		for (i = 0; i < fill; i++) begin
			if (key_mem[p] != k) begin
				keep[n] = key_mem[p];
				n++;
			end
			p = p + 1'b1;
		end
		for (i = 0; i < n; i++)
			key_mem[i] = keep[i];
		head_ptr = '0;
		tail_ptr = slot_t'(n);
		fill     = level_t'(n);
		if (n > 0) begin
			cur_key = key_mem[0];
			pending = 1'b1;
		end else if (cur_key == k) begin
			cur_key = '0;
			pending = 1'b0;
		end
	endfunction

	function void note_command(logic [1:0] m, logic [7:0] k, logic [1:0] o);
		key_result_t w;
		w = '0;
		case (m)
			MODE_PRESS: begin
				if (k != 8'h00 && fill < KBF_DEPTH) begin
					key_mem[tail_ptr] = k;
					tail_ptr          = tail_ptr + 1'b1;
					fill              = fill + 1'b1;
					if (!pending) begin
						cur_key = k;
						pending = 1'b1;
					end
					w.accepted = 1'b1;
				end
			end
			MODE_RELEASE: release_key(k);
			MODE_READ: begin
				case (o)
					OFF_STATUS:   w.data = STATUS_CONNECTED | (pending ? STATUS_PENDING : 8'h00);
					OFF_CURRENT: begin
						w.data = cur_key;
						void'(pop_key());
					end
					OFF_MODIFIER: w.data = 8'h00;
					default:      w.data = pop_key();
				endcase
			end
			default: ;
		endcase
		w.irq = pending;
		expected_words.push_back(w);
	endfunction

	function void check_word(logic [7:0] data, logic acc, logic irq);
		key_result_t w;
		if (expected_words.size() == 0) begin
			$display("%0t: result word with none expected: read_data %h accepted %b irq %b",
				$time, data, acc, irq);
			errors++;
			return;
		end
		w = expected_words.pop_front();
		if (data !== w.data) begin
			$display("%0t: read_data expected %h actual %h", $time, w.data, data);
			errors++;
		end
		if (acc !== w.accepted) begin
			$display("%0t: accepted expected %b actual %b", $time, w.accepted, acc);
			errors++;
		end
		if (irq !== w.irq) begin
			$display("%0t: irq expected %b actual %b", $time, w.irq, irq);
			errors++;
		end
	endfunction
endclass

module keyboard_fifo_registers_core_tb;
	import kbf_pkg::*;

	// mode code that the block leaves unused
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	// cycles with no word moving either way before the run is called hung
	localparam int STALL_LIMIT = 1000;
	// words per random phase and number of phases
	localparam int PHASE_WORDS = 50;
	localparam int PHASES      = 35;

	// phase flavors: fill pushes hard, mixed balances, drain mostly reads
	localparam int PHASE_FILL  = 0;
	localparam int PHASE_MIXED = 1;
	localparam int PHASE_DRAIN = 2;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       start      = 1'b0;
	logic [1:0] mode       = MODE_PRESS;
	logic [7:0] key        = 8'h00;
	logic [1:0] reg_offset = OFF_STATUS;
	logic       busy;
	logic       done;
	logic [7:0] read_data;
	logic       accepted;
	logic       irq;

	key_fifo_checker scoreboard;
	int              stall_cycles = 0;
	bit              gaps_on      = 1'b1;

	keyboard_fifo_registers_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.key        (key),
		.reg_offset (reg_offset),
		.done       (done),
		.read_data  (read_data),
		.accepted   (accepted),
		.irq        (irq)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// monitor: note accepted command words, check result words, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy || done)
				stall_cycles = 0;
			else
				stall_cycles++;
			// note before check so a word is predicted before its result can land
			if (start && !busy)
				scoreboard.note_command(mode, key, reg_offset);
			if (done)
				scoreboard.check_word(read_data, accepted, irq);
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("FAIL keyboard_fifo_registers_core");
				$finish;
			end
		end
	end

	// present one command word and hold it until the block takes it
	// start stays high on return so back-to-back words need no extra edge
	task automatic send_word(input logic [1:0] m, input logic [7:0] k, input logic [1:0] o);
		start      <= 1'b1;
		mode       <= m;
		key        <= k;
		reg_offset <= o;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// sender goes quiet for a few cycles
	task automatic hold_off(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// sender goes quiet until every predicted result word has come back
	task automatic wait_for_results();
		start <= 1'b0;
		@(posedge clk);
		while (scoreboard.expected_words.size() != 0)
			@(posedge clk);
	endtask

	// one random command word, mix depends on the phase flavor
	task automatic send_random(input int flavor);
		int         roll;
		int         press_cut;
		int         release_cut;
		logic [1:0] m;
		logic [7:0] k;
		logic [1:0] o;
		case (flavor)
			PHASE_FILL: begin
				press_cut   = 85;
				release_cut = 89;
			end
			PHASE_MIXED: begin
				press_cut   = 45;
				release_cut = 65;
			end
			default: begin
				press_cut   = 15;
				release_cut = 40;
			end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < press_cut)
			m = MODE_PRESS;
		else if (roll < release_cut)
			m = MODE_RELEASE;
		else if (roll < 98)
			m = MODE_READ;
		else
			m = MODE_UNUSED;
		// a small key set makes duplicates, so releases have copies to compact
		if ($urandom_range(0, 9) < 6)
			k = 8'($urandom_range(0, 6));
		else
			k = 8'($urandom_range(0, 255));
		o = 2'($urandom_range(0, 3));
		send_word(m, k, o);
		if (gaps_on && $urandom_range(0, 99) < 10)
			hold_off($urandom_range(1, 5));
	endtask

	initial begin
		int phase;
		scoreboard = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero key rejected, pop on an empty fifo before any press
		send_word(MODE_PRESS, 8'h00, OFF_STATUS);
		send_word(MODE_READ, 8'h00, OFF_POP);
		// queue extremes and a duplicate
		send_word(MODE_PRESS, 8'hff, OFF_MODIFIER);
		send_word(MODE_PRESS, 8'h01, OFF_POP);
		send_word(MODE_PRESS, 8'hff, OFF_CURRENT);
		send_word(MODE_PRESS, 8'h80, OFF_STATUS);
		send_word(MODE_READ, 8'h00, OFF_STATUS);
		send_word(MODE_READ, 8'hff, OFF_MODIFIER);
		// release with compaction of the survivors
		send_word(MODE_RELEASE, 8'hff, OFF_STATUS);
		send_word(MODE_READ, 8'h00, OFF_CURRENT);
		send_word(MODE_READ, 8'h00, OFF_POP);
		// pop on empty returns the current key and leaves pending clear
		send_word(MODE_READ, 8'h00, OFF_POP);
		send_word(MODE_READ, 8'h00, OFF_CURRENT);
		send_word(MODE_READ, 8'h00, OFF_STATUS);
		// release of the current key with an empty fifo clears it
		send_word(MODE_PRESS, 8'h55, OFF_STATUS);
		send_word(MODE_READ, 8'h00, OFF_POP);
		send_word(MODE_RELEASE, 8'h55, OFF_STATUS);
		send_word(MODE_READ, 8'h00, OFF_CURRENT);
		// release of a key that is nowhere
		send_word(MODE_PRESS, 8'h2a, OFF_STATUS);
		send_word(MODE_RELEASE, 8'h7f, OFF_POP);
		// unused mode changes nothing
		send_word(MODE_UNUSED, 8'haa, OFF_POP);
		send_word(MODE_READ, 8'h00, OFF_STATUS);
		// sender waits here for every result word at least once
		wait_for_results();

		// random phases; filling phases push the fifo to full and past it
		for (phase = 0; phase < PHASES; phase++) begin
			// long stretch with the sender never pausing
			gaps_on = !(phase >= 12 && phase < 18);
			repeat (PHASE_WORDS) send_random(phase % 3);
			if ($urandom_range(0, 3) == 0)
				wait_for_results();
		end

		// drain, then let any late word show up
		wait_for_results();
		repeat (20) @(posedge clk);
		if (scoreboard.errors == 0 && scoreboard.expected_words.size() == 0) begin
			$display("PASS keyboard_fifo_registers_core");
		end else begin
			$display("FAIL keyboard_fifo_registers_core");
		end
		$finish;
	end

endmodule
